// ----- src/ecpvp_pkg.sv -----
// Shared types and constants for the enhanced clock victim picker.
package ecpvp_pkg;

   localparam int MAX_FRAMES = 32;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = FRAME_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(MAX_FRAMES);

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LOAD  = 2'd2,
      CMD_PICK  = 2'd3
   } cmd_type;

   // Register index from paddr[2]
   typedef enum logic {
      REG_POLICY = 1'b0,
      REG_FRAMES = 1'b1
   } reg_type;

   typedef enum logic {
      POLICY_CLOCK = 1'b0,
      POLICY_FIFO  = 1'b1
   } policy_type;

   typedef enum logic [1:0] {
      PASS_CLEAN_A = 2'd0,
      PASS_DIRTY   = 2'd1,
      PASS_CLEAN_B = 2'd2,
      PASS_TAKE    = 2'd3
   } pass_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1
   } state_type;

   typedef struct packed {
      logic access_en;
      logic pick_fifo;
      logic scan_start;
      logic scan_step;
   } dp_cmd_type;

   typedef struct packed {
      logic     out_free;
      logic     policy_fifo;
      logic     hit;
      pass_type pass;
   } dp_status_type;

endpackage

// ----- src/ecpvp_csr.sv -----
// Configuration register block: policy mode and managed frame count.
module ecpvp_csr
   import ecpvp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output policy_type            policy_o,
   output logic [COUNT_W-1:0]    frames_o
);

   policy_type         policy_ff, policy_in;
   logic [COUNT_W-1:0] frames_ff, frames_in;
   logic               wr_en;
   reg_type            reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_type'(csr_paddr[2]);

   always_comb begin
      policy_in = policy_ff;
      frames_in = frames_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_POLICY: policy_in = policy_type'(csr_pwdata[0]);
            REG_FRAMES: frames_in = csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_POLICY: csr_prdata = CSR_DATA_W'(policy_ff);
         REG_FRAMES: csr_prdata = CSR_DATA_W'(frames_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_CLOCK;
         frames_ff <= FRAMES_RESET;
      end else begin
         policy_ff <= policy_in;
         frames_ff <= frames_in;
      end
   end

   assign policy_o = policy_ff;
   assign frames_o = frames_ff;

endmodule

// ----- src/ecpvp_ctrl.sv -----
// Controller state machine: accepts words and sequences the clock scan.
module ecpvp_ctrl
   import ecpvp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  cmd_type       req_cmd,
   output logic          req_tready,
   input  dp_status_type status_i,
   output dp_cmd_type    cmd_o
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd_o      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = status_i.out_free;
            if (req_tvalid && status_i.out_free) begin
               if (req_cmd == CMD_PICK) begin
                  if (status_i.policy_fifo) begin
                     cmd_o.pick_fifo = 1'b1;
                  end else begin
                     cmd_o.scan_start = 1'b1;
                     state_in         = ST_SCAN;
                  end
               end else begin
                  cmd_o.access_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd_o.scan_step = 1'b1;
            if (status_i.hit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- src/ecpvp_datapath.sv -----
// Datapath: use/dirty bit vectors, hand, scan counters and result register.
module ecpvp_datapath
   import ecpvp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd_i,
   output dp_status_type      status_o,
   input  cmd_type            req_cmd,
   input  logic [FRAME_W-1:0] req_frame,
   input  policy_type         policy_i,
   input  logic [COUNT_W-1:0] frames_i,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic               rsp_flag,
   output logic [FRAME_W-1:0] rsp_frame,
   output logic               rsp_dirty
);

   logic [MAX_FRAMES-1:0] use_ff, use_in;
   logic [MAX_FRAMES-1:0] dirty_ff, dirty_in;
   logic [FRAME_W-1:0]    hand_ff, hand_in;
   pass_type              pass_ff, pass_in;
   logic [FRAME_W-1:0]    step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_flag_ff, rsp_flag_in;
   logic [FRAME_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                  rsp_dirty_ff, rsp_dirty_in;

   logic [COUNT_W-1:0]    count;
   logic [FRAME_W-1:0]    last_frame;
   logic [FRAME_W-1:0]    hand_clamp;
   logic [FRAME_W-1:0]    hand_next;
   logic [FRAME_W-1:0]    clamp_next;
   logic                  idx_ok;
   logic                  cur_use;
   logic                  cur_dirty;
   logic                  hit;

   // managed count clamped to 1..MAX_FRAMES
   always_comb begin
      if (frames_i == '0) begin
         count = COUNT_W'(1);
      end else if (frames_i > COUNT_W'(MAX_FRAMES)) begin
         count = COUNT_W'(MAX_FRAMES);
      end else begin
         count = frames_i;
      end
   end

   assign last_frame = FRAME_W'(count - COUNT_W'(1));
   assign hand_clamp = ({1'b0, hand_ff} >= count) ? '0 : hand_ff;
   assign hand_next  = (hand_ff == last_frame) ? '0 : hand_ff + FRAME_W'(1);
   assign clamp_next = (hand_clamp == last_frame) ? '0 : hand_clamp + FRAME_W'(1);
   assign idx_ok     = {1'b0, req_frame} < count;
   assign cur_use    = use_ff[hand_ff];
   assign cur_dirty  = dirty_ff[hand_ff];

   always_comb begin
      case (pass_ff)
         PASS_CLEAN_A, PASS_CLEAN_B: hit = !cur_use && !cur_dirty;
         PASS_DIRTY:                 hit = !cur_use && cur_dirty;
         PASS_TAKE:                  hit = 1'b1;
         default:                    hit = 1'b1;
      endcase
   end

   always_comb begin
      use_in       = use_ff;
      dirty_in     = dirty_ff;
      hand_in      = hand_ff;
      pass_in      = pass_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_dirty_in = rsp_dirty_ff;

      if (cmd_i.access_en) begin
         if (idx_ok) begin
            case (req_cmd)
               CMD_READ: use_in[req_frame] = 1'b1;
               CMD_WRITE: begin
                  use_in[req_frame]   = 1'b1;
                  dirty_in[req_frame] = 1'b1;
               end
               CMD_LOAD: begin
                  use_in[req_frame]   = 1'b1;
                  dirty_in[req_frame] = 1'b0;
               end
               default: ;
            endcase
         end
         rsp_valid_in = 1'b1;
         rsp_flag_in  = 1'b0;
         rsp_frame_in = '0;
         rsp_dirty_in = 1'b0;
      end

      if (cmd_i.pick_fifo) begin
         hand_in      = clamp_next;
         rsp_valid_in = 1'b1;
         rsp_flag_in  = 1'b1;
         rsp_frame_in = hand_clamp;
         rsp_dirty_in = dirty_ff[hand_clamp];
      end

      if (cmd_i.scan_start) begin
         hand_in = hand_clamp;
         pass_in = PASS_CLEAN_A;
         step_in = '0;
      end

      // one frame per cycle; a full lap of misses moves to the next pass
      if (cmd_i.scan_step) begin
         hand_in = hand_next;
         if (hit) begin
            rsp_valid_in = 1'b1;
            rsp_flag_in  = 1'b1;
            rsp_frame_in = hand_ff;
            rsp_dirty_in = cur_dirty;
         end else begin
            if (pass_ff == PASS_DIRTY) begin
               use_in[hand_ff] = 1'b0;
            end
            if (step_ff == last_frame) begin
               step_in = '0;
               pass_in = pass_type'(pass_ff + 2'd1);
            end else begin
               step_in = step_ff + FRAME_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff       <= '0;
         dirty_ff     <= '0;
         hand_ff      <= '0;
         pass_ff      <= PASS_CLEAN_A;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         use_ff       <= use_in;
         dirty_ff     <= dirty_in;
         hand_ff      <= hand_in;
         pass_ff      <= pass_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flag_ff  <= rsp_flag_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   assign status_o.out_free    = !rsp_valid_ff || rsp_tready;
   assign status_o.policy_fifo = (policy_i == POLICY_FIFO);
   assign status_o.hit         = hit;
   assign status_o.pass        = pass_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_frame  = rsp_frame_ff;
   assign rsp_dirty  = rsp_dirty_ff;

endmodule

// ----- src/enhanced_clock_page_victim_picker_unit.sv -----
// Access/load words and FIFO picks give their result in the cycle after accept.
// Clock-mode picks scan one frame per cycle through the N managed frames.
// Words are handled one at a time; the scan over the use/dirty vectors sets the pick rate.
// A new word is taken once the result register is empty or being drained.
// Reset (synchronous): use and dirty bits cleared, hand at frame 0, clock mode,
// 32 frames managed.
module enhanced_clock_page_victim_picker_unit
   import ecpvp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [4:0] frame_index, [7:5] zero
   input  logic [1:0]            req_tuser,   // [1:0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [4:0] victim_frame, [5] victim_dirty, [7:6] 0
   output logic                  rsp_tuser,   // [0] victim_valid
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   policy_type         policy;
   logic [COUNT_W-1:0] frames;
   dp_cmd_type         dp_cmd;
   dp_status_type      dp_status;
   cmd_type            req_cmd;
   logic [FRAME_W-1:0] rsp_frame;
   logic               rsp_dirty;

   assign req_cmd = cmd_type'(req_tuser);

   ecpvp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .policy_o    (policy),
      .frames_o    (frames)
   );

   ecpvp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_cmd),
      .req_tready (req_tready),
      .status_i   (dp_status),
      .cmd_o      (dp_cmd)
   );

   ecpvp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (dp_cmd),
      .status_o   (dp_status),
      .req_cmd    (req_cmd),
      .req_frame  (req_tdata[FRAME_W-1:0]),
      .policy_i   (policy),
      .frames_i   (frames),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_flag   (rsp_tuser),
      .rsp_frame  (rsp_frame),
      .rsp_dirty  (rsp_dirty)
   );

   assign rsp_tdata = {2'b00, rsp_dirty, rsp_frame};

   // a clock-mode pick holds off the input while the scan runs
   a_scan_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_cmd == CMD_PICK) && (policy == POLICY_CLOCK)
      |=> !req_tready)
      else $error("input accepted during clock scan");

   // access and load words answer on the next cycle with an empty result
   a_access_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_cmd != CMD_PICK)
      |=> rsp_tvalid && !rsp_tuser && (rsp_tdata == 8'd0))
      else $error("access word gave wrong result");

   // the last pass always finds a victim
   a_take_pass_hits: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.scan_step && (dp_status.pass == PASS_TAKE) |-> dp_status.hit)
      else $error("scan ran past the last pass");

   // a scan ends by loading a pick result
   a_scan_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.scan_step && dp_status.hit |=> rsp_tvalid && rsp_tuser)
      else $error("scan hit produced no result");

endmodule
